// ===== sv/ep_pkg.sv =====
`default_nettype none

package ep_pkg;

  localparam int ALPHABET   = 26;
  localparam int COUNT_BITS = 17;
  localparam int NODE_BITS  = 5;
  localparam int IDX_BITS   = $clog2(ALPHABET);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ALPHABET-1:0]   node_set_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic upd;
    logic seed;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // status from the datapath back to the controller
  typedef struct packed {
    logic walk_done;
    logic sweep_done;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/ep_if.sv =====
`default_nettype none

interface ep_in_if;
  import ep_pkg::*;

  logic  valid;
  logic  ready;
  node_t first_letter;
  node_t last_letter;
  logic  last_word;

  modport source (output valid, output first_letter, output last_letter, output last_word,
                  input ready);
  modport sink (input valid, input first_letter, input last_letter, input last_word,
                output ready);
endinterface

interface ep_out_if;
  logic valid;
  logic ready;
  logic possible;
  logic overflow;

  modport source (output valid, output possible, output overflow, input ready);
  modport sink (input valid, input possible, input overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/euler_path_existence_check.sv =====
`default_nettype none

// Directed Eulerian path check over a 26-letter alphabet. Each input beat carries one
// word as an edge from its first letter to its last letter; letters outside the alphabet
// drop the edge, but a last_word flag on such a beat still starts the check. Ordinary
// words are taken one per cycle while the controller is idle. The beat flagged last_word
// starts the check: a connectivity walk that expands one node per cycle (each letter at
// most once) runs beside a degree sweep that visits one node per cycle through the
// single read port of each count array, so the sweep length sets the check time. The
// check state ends by waiting on the registered sweep-done flag; in_ready stays low
// through the seed, check and finish steps, and the next word is taken once the
// controller is back in idle. One verdict beat follows each set: possible says an
// ordering exists, overflow says some 17-bit degree counter saturated (saturated values
// then enter the check as they stand). The verdict sits in an output register, so a new
// set can stream in while it waits; a second verdict holds in the finish step until the
// first one is taken. All degree counts, links and marks clear when the verdict is
// loaded and at reset.
module euler_path_existence_check (
  input wire logic clk,
  input wire logic rst_n,
  ep_in_if.sink    in_ch,
  ep_out_if.source out_ch
);
  import ep_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept words, run the check, hand the verdict to the output register
  ep_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_last_word (in_ch.last_word),
    .in_ready     (in_ch.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // degree counts, adjacency rows, walk and sweep, verdict register
  ep_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .first_letter (in_ch.first_letter),
    .last_letter  (in_ch.last_letter),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .possible     (out_ch.possible),
    .overflow     (out_ch.overflow)
  );

endmodule

`default_nettype wire

// ===== sv/ep_ctrl.sv =====
`default_nettype none

module ep_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_word,
  output logic                   in_ready,
  output ep_pkg::ctrl_cmd_t      cmd,
  input  wire ep_pkg::dp_stat_t  stat
);
  import ep_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last_word) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.walk_done && stat.sweep_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.upd  = in_valid;
      end
      ST_SEED: begin
        cmd.seed = 1'b1;
      end
      ST_CHECK: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ep_dp.sv =====
`default_nettype none

module ep_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ep_pkg::ctrl_cmd_t cmd,
  output ep_pkg::dp_stat_t       stat,
  input  wire ep_pkg::node_t     first_letter,
  input  wire ep_pkg::node_t     last_letter,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   possible,
  output logic                   overflow
);
  import ep_pkg::*;

  localparam node_set_t ONE = node_set_t'(1);

  count_t    out_cnt_r [ALPHABET];
  count_t    in_cnt_r  [ALPHABET];
  node_set_t link_r    [ALPHABET];
  node_set_t present_r;
  logic      sat_r;

  node_set_t reached_r;
  node_set_t visited_r;

  logic [IDX_BITS-1:0] idx_r;
  logic                sweep_done_r;
  logic [1:0]          odd_r;
  logic [1:0]          plus_r;
  logic [1:0]          minus_r;

  logic out_valid_r;
  logic possible_r;
  logic overflow_r;

  logic [IDX_BITS-1:0] rd_a;
  logic [IDX_BITS-1:0] rd_b;
  count_t              oc;
  count_t              ic;
  logic                edge_ok;
  node_set_t           a_oh;
  node_set_t           b_oh;
  node_set_t           pending;
  node_set_t           pick_oh;
  node_set_t           row_or;
  logic                unbal;
  logic                is_plus;
  logic                is_minus;
  logic                conn_ok;
  logic                deg_ok;

  // one read port per count array: the letter during updates, the sweep index in the check
  assign edge_ok = (first_letter < NODE_BITS'(ALPHABET)) && (last_letter < NODE_BITS'(ALPHABET));
  assign rd_a    = cmd.step ? idx_r : first_letter[IDX_BITS-1:0];
  assign rd_b    = cmd.step ? idx_r : last_letter[IDX_BITS-1:0];
  assign oc      = out_cnt_r[rd_a];
  assign ic      = in_cnt_r[rd_b];
  assign a_oh    = ONE << first_letter;
  assign b_oh    = ONE << last_letter;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      for (int i = 0; i < ALPHABET; i++) begin
        out_cnt_r[i] <= '0;
        in_cnt_r[i]  <= '0;
        link_r[i]    <= '0;
      end
      present_r <= '0;
      sat_r     <= 1'b0;
    end else if (cmd.upd && edge_ok) begin
      out_cnt_r[rd_a] <= (oc == COUNT_MAX) ? oc : oc + COUNT_BITS'(1);
      in_cnt_r[rd_b]  <= (ic == COUNT_MAX) ? ic : ic + COUNT_BITS'(1);
      // link both ends in one write per row, a self-loop included
      for (int i = 0; i < ALPHABET; i++) begin
        link_r[i] <= link_r[i] | ({ALPHABET{a_oh[i]}} & b_oh) | ({ALPHABET{b_oh[i]}} & a_oh);
      end
      present_r       <= present_r | a_oh | b_oh;
      if ((oc == COUNT_MAX) || (ic == COUNT_MAX)) sat_r <= 1'b1;
    end
  end

  // walk: expand the lowest reached node not yet visited, one node per cycle
  assign pending = reached_r & ~visited_r;
  assign pick_oh = pending & (~pending + ONE);

  always_comb begin
    row_or = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (pick_oh[i]) row_or = row_or | link_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      reached_r <= '0;
      visited_r <= '0;
    end else if (cmd.seed) begin
      reached_r <= present_r & (~present_r + ONE);
      visited_r <= '0;
    end else if (cmd.step && (pending != '0)) begin
      reached_r <= reached_r | row_or;
      visited_r <= visited_r | pick_oh;
    end
  end

  // degree sweep over all nodes
  assign unbal    = (oc != ic);
  assign is_plus  = ({1'b0, oc} == ({1'b0, ic} + (COUNT_BITS+1)'(1)));
  assign is_minus = ({1'b0, ic} == ({1'b0, oc} + (COUNT_BITS+1)'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.seed) begin
      idx_r        <= '0;
      sweep_done_r <= 1'b0;
      odd_r        <= '0;
      plus_r       <= '0;
      minus_r      <= '0;
    end else if (cmd.step && !sweep_done_r) begin
      idx_r <= idx_r + IDX_BITS'(1);
      if (idx_r == IDX_BITS'(ALPHABET - 1)) sweep_done_r <= 1'b1;
      if (unbal && (odd_r != 2'd3)) odd_r <= odd_r + 2'd1;
      if (is_plus && (plus_r != 2'd3)) plus_r <= plus_r + 2'd1;
      if (is_minus && (minus_r != 2'd3)) minus_r <= minus_r + 2'd1;
    end
  end

  assign conn_ok = ((present_r & ~reached_r) == '0);
  assign deg_ok  = (odd_r == 2'd0) ||
                   ((odd_r == 2'd2) && (plus_r == 2'd1) && (minus_r == 2'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      possible_r <= conn_ok && deg_ok;
      overflow_r <= sat_r;
    end
  end

  assign stat.walk_done  = (pending == '0);
  assign stat.sweep_done = sweep_done_r;
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign possible  = possible_r;
  assign overflow  = overflow_r;

endmodule

`default_nettype wire

// ===== tb/euler_path_existence_check_test.sv =====
`timescale 1ns / 100ps

module euler_path_existence_check_test;
  import ep_pkg::*;

  // Verdict as it leaves the block: possible, then overflow.
  typedef struct packed {
    logic possible;
    logic overflow;
  } verdict_t;

  // One row of the directed table. Where fixed is set, the verdict typed into the row is
  // the expectation; otherwise the path predictor supplies it.
  typedef struct packed {
    node_t first;
    node_t last;
    logic  final_word;
    logic  fixed;
    logic  possible;
    logic  overflow;
  } word_row_t;

  localparam int DIR_ROWS = 22;
  localparam int RANDOM_WORDS = 1750;
  localparam int DRAIN_CYCLES = 64;

  localparam word_row_t DIRECTED [DIR_ROWS] = '{
    // empty set right after reset: out-of-range first letter, verdict holds vacuously
    '{5'd26, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
    // both letters at the top of the field, still an empty set
    '{5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0},
    // single edge across the whole alphabet: one source, one sink
    '{5'd0,  5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
    // self-loop on the last letter, balanced
    '{5'd25, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
    // three-node cycle, all balanced and connected
    '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd1,  5'd2,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd2,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    // two balanced islands, not connected
    '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd1,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd5,  5'd6,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd6,  5'd5,  1'b1, 1'b0, 1'b0, 1'b0},
    // three unbalanced nodes
    '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd0,  5'd2,  1'b1, 1'b0, 1'b0, 1'b0},
    // two unbalanced nodes, off by two
    '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd0,  5'd1,  1'b1, 1'b0, 1'b0, 1'b0},
    // out-of-range edge in the middle of a set is dropped
    '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd30, 5'd3,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd1,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    // out-of-range last letter on the final word, empty set
    '{5'd3,  5'd27, 1'b1, 1'b1, 1'b1, 1'b0},
    // path with the source on the last letter
    '{5'd24, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd0,  5'd24, 1'b0, 1'b0, 1'b0, 1'b0},
    '{5'd25, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;

  ep_in_if  in_ch ();
  ep_out_if out_ch ();

  euler_path_existence_check dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: degree counts, undirected links, present nodes, saturation flag.
  count_t    in_deg [ALPHABET];
  count_t    out_deg [ALPHABET];
  node_set_t links [ALPHABET];
  node_set_t present_nodes;
  logic      saturated;

  verdict_t  pending_verdicts [$];
  int        mismatches;
  logic      quiet_sender;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4000000;
    $display("euler_path_existence_check: mismatch");
    $finish;
  end

  function automatic count_t bump_degree(count_t c);
    if (c == COUNT_MAX) begin
      saturated = 1'b1;
      return c;
    end
    return c + 1'b1;
  endfunction

  task automatic clear_graph();
    for (int i = 0; i < ALPHABET; i++) begin
      in_deg[i]  = '0;
      out_deg[i] = '0;
      links[i]   = '0;
    end
    present_nodes = '0;
    saturated     = 1'b0;
  endtask

  // Apply one accepted word to the predictor; on the final word produce the verdict.
  task automatic predict_path(input node_t f, input node_t l, input logic fin,
                              output logic emits, output verdict_t v);
    node_set_t reach;
    logic      linked;
    logic      balanced;
    int        odd;
    int        src;
    int        dst;
    if (f < ALPHABET && l < ALPHABET) begin
      out_deg[f] = bump_degree(out_deg[f]);
      in_deg[l]  = bump_degree(in_deg[l]);
      present_nodes[f] = 1'b1;
      present_nodes[l] = 1'b1;
      links[f][l] = 1'b1;
      links[l][f] = 1'b1;
    end
    emits = fin;
    v = '0;
    if (fin) begin
      // flood from the lowest present node; ALPHABET rounds reach every component member
      reach = present_nodes & (~present_nodes + 1'b1);
      repeat (ALPHABET) begin
        for (int i = 0; i < ALPHABET; i++) begin
          if (reach[i]) reach |= links[i];
        end
      end
      linked = ((present_nodes & ~reach) == '0);
      odd = 0;
      src = -1;
      dst = -1;
      for (int i = 0; i < ALPHABET; i++) begin
        if (in_deg[i] != out_deg[i]) begin
          odd++;
          if (src < 0) src = i;
          else if (dst < 0) dst = i;
        end
      end
      if (odd == 0) begin
        balanced = 1'b1;
      end else if (odd != 2) begin
        balanced = 1'b0;
      end else begin
        // widen before adding one so a saturated count never wraps
        balanced = (32'(out_deg[src]) == 32'(in_deg[src]) + 1 &&
                    32'(in_deg[dst]) == 32'(out_deg[dst]) + 1) ||
                   (32'(out_deg[dst]) == 32'(in_deg[dst]) + 1 &&
                    32'(in_deg[src]) == 32'(out_deg[src]) + 1);
      end
      v.possible = linked && balanced;
      v.overflow = saturated;
      clear_graph();
    end
  endtask

  // Mostly short gaps, a few long ones; none in quiet stretches.
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one word, hold it until accepted, then log its expected verdict.
  task automatic send_word(input node_t f, input node_t l, input logic fin,
                           input logic fixed, input verdict_t fixed_v);
    int       gap;
    logic     emits;
    verdict_t v;
    gap = pick_gap(quiet_sender);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.first_letter <= f;
    in_ch.last_letter  <= l;
    in_ch.last_word    <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_path(f, l, fin, emits, v);
    if (fixed) v = fixed_v;
    if (emits) pending_verdicts = {pending_verdicts, v};
  endtask

  // One random set. Most sets are walks, which admit a path unless a stray letter drops an
  // edge; some have one broken edge, some are loose edges over a few nodes, the rest raw noise.
  task automatic run_random_set(inout int counted);
    int    kind;
    int    span;
    int    base;
    int    len;
    int    bad;
    int    cur;
    int    nxt;
    node_t f;
    node_t l;
    logic  fin;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 6) : $urandom_range(7, ALPHABET);
    base = $urandom_range(0, ALPHABET - span);
    len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
    bad  = $urandom_range(0, len - 1);
    cur  = base + $urandom_range(0, span - 1);
    quiet_sender = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      nxt = base + $urandom_range(0, span - 1);
      f = node_t'(cur);
      l = node_t'(nxt);
      if (kind >= 55 && kind < 75 && k == bad) begin
        f = node_t'(base + $urandom_range(0, span - 1));
        l = node_t'(base + $urandom_range(0, span - 1));
      end else if (kind >= 75 && kind < 90) begin
        f = node_t'(base + $urandom_range(0, span - 1));
      end else if (kind >= 90) begin
        f = node_t'($urandom_range(0, 31));
        l = node_t'($urandom_range(0, 31));
      end
      // occasional stray letter past the alphabet
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1) == 1) f = node_t'($urandom_range(ALPHABET, 31));
        else l = node_t'($urandom_range(ALPHABET, 31));
      end
      cur = nxt;
      fin = (k == len - 1);
      send_word(f, l, fin, 1'b0, '0);
      if (fin || (f < ALPHABET && l < ALPHABET)) counted++;
    end
  endtask

  // Result side: compare each verdict beat, then pick the next ready level.
  initial begin
    int       stall_left;
    logic     steady;
    verdict_t want;
    out_ch.ready = 1'b0;
    stall_left = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected verdict beat: possible=%0b overflow=%0b",
                     out_ch.possible, out_ch.overflow);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.possible !== want.possible || out_ch.overflow !== want.overflow) begin
            if (mismatches < 10)
              $display("verdict differs: expected possible=%0b overflow=%0b, got %0b %0b",
                       want.possible, want.overflow, out_ch.possible, out_ch.overflow);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) steady = ~steady;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
    end
  end

  // Stimulus: directed table, then random sets.
  initial begin
    int       counted;
    verdict_t typed;
    mismatches = 0;
    quiet_sender = 1'b0;
    clear_graph();
    in_ch.valid        = 1'b0;
    in_ch.first_letter = '0;
    in_ch.last_letter  = '0;
    in_ch.last_word    = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      typed.possible = DIRECTED[r].possible;
      typed.overflow = DIRECTED[r].overflow;
      send_word(DIRECTED[r].first, DIRECTED[r].last, DIRECTED[r].final_word,
                DIRECTED[r].fixed, typed);
    end

    counted = 0;
    while (counted < RANDOM_WORDS) run_random_set(counted);

    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("euler_path_existence_check: match");
    end else begin
      $display("euler_path_existence_check: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ep_pkg.sv
sv/ep_if.sv
sv/ep_ctrl.sv
sv/ep_dp.sv
sv/euler_path_existence_check.sv
tb/euler_path_existence_check_test.sv
